[rtl/largest_occluder_selection_unit_defines.svh]
// Assertion macros used by the checker file of the occluder selection block.
`ifndef LARGEST_OCCLUDER_SELECTION_UNIT_DEFINES_SVH
`define LARGEST_OCCLUDER_SELECTION_UNIT_DEFINES_SVH

// Concurrent assertion clocked on clk and disabled while rst_n is low.
`define LOS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define LOS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/los_pkg.sv]
package los_pkg;

  // Field widths of the beats.
  localparam int unsigned AREA_W  = 52;
  localparam int unsigned TAG_W   = 20;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned SUM_W   = 26;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned OP_W    = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Reset value of the threshold, 4.0 in Q.16.
  localparam logic [AREA_W-1:0] MIN_AREA_RST = 52'd262144;

  // One list entry as held by a cell.
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

[rtl/largest_occluder_selection_unit.sv]
// Offers and clears are taken one per cycle while in_stall_o is low and reach the list through
// the edge-sum and product registers; every cell compares against the new area at once.
// A readout gives max(kept count, 1) beats; the first is offered after passing the pipeline
// registers and the sequencer state, and the rest follow one per cycle while out_stall_i
// is low. Input stalls from readout acceptance until its last beat is in the output register.
// Reset empties the list and sets min_area to 4.0; entries need no sweep.
module largest_occluder_selection_unit #(
  parameter int unsigned MAX_QUADS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [los_pkg::AREA_W-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [los_pkg::OP_W-1:0]     operation_i,
  input  logic        [los_pkg::TAG_W-1:0]    quad_tag_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_z_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_z_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [los_pkg::TAG_W-1:0]    kept_tag_o,
  output logic        [los_pkg::AREA_W-1:0]   kept_area_o,
  output logic        [los_pkg::RANK_W-1:0]   rank_o,
  output logic                                is_last_o,
  output logic                                is_empty_o
);

  localparam int unsigned CNT_W = $clog2(MAX_QUADS + 1);
  localparam int unsigned IDX_W = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_QUADS);

  // Readout sequencer codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                        in_acc;
  logic [los_pkg::AREA_W-1:0]  min_area_q;

  logic                        v1_q, v2_q;
  logic [los_pkg::OP_W-1:0]    op1_q, op2_q;
  logic [los_pkg::TAG_W-1:0]   tag1_q, tag2_q;
  logic [los_pkg::AREA_W-1:0]  area2;

  logic [CNT_W-1:0]            count_d, count_q;
  logic                        ins_en;
  logic [CNT_W-1:0]            last_pos;

  logic                        st_d, st_q;
  logic [IDX_W-1:0]            rd_idx_d, rd_idx_q;
  logic                        rd_load;
  logic                        rd_last;

  logic                        out_valid_d, out_valid_q;
  logic [los_pkg::TAG_W-1:0]   out_tag_d, out_tag_q;
  logic [los_pkg::AREA_W-1:0]  out_area_d, out_area_q;
  logic [los_pkg::RANK_W-1:0]  out_rank_d, out_rank_q;
  logic                        out_last_d, out_last_q;
  logic                        out_empty_d, out_empty_q;

  los_pkg::entry_t             new_ent;
  los_pkg::entry_t             cell_ent [MAX_QUADS];
  logic                        cell_gt  [MAX_QUADS];

  // Input is held off while a readout is in flight or being emitted.
  assign in_stall_o = (st_q == ST_READ)
                   || (v1_q && (op1_q == los_pkg::OP_READ))
                   || (v2_q && (op2_q == los_pkg::OP_READ));
  assign in_acc = in_valid_i && !in_stall_o;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q <= los_pkg::MIN_AREA_RST;
    end else if (cfg_we_i) begin
      min_area_q <= cfg_wdata_i;
    end
  end

  // Area pipeline, two stages.
  los_area u_area (
    .clk_i      (clk_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .side_a_x_i (side_a_x_i),
    .side_a_y_i (side_a_y_i),
    .side_a_z_i (side_a_z_i),
    .side_b_x_i (side_b_x_i),
    .side_b_y_i (side_b_y_i),
    .side_b_z_i (side_b_z_i),
    .area_o     (area2)
  );

  // Beat control travels alongside the area pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= operation_i;
    tag1_q <= quad_tag_i;
    op2_q  <= op1_q;
    tag2_q <= tag1_q;
  end

  // Insertion into the chain of cells.
  assign ins_en  = v2_q && (op2_q == los_pkg::OP_OFFER) && (area2 >= min_area_q);
  assign new_ent = '{area: area2, tag: tag2_q};

  for (genvar i = 0; i < MAX_QUADS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(i);
    los_pkg::entry_t prev_ent;
    logic            prev_gt;
    if (i == 0) begin : g_head
      assign prev_ent = new_ent;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_ent = cell_ent[i-1];
      assign prev_gt  = cell_gt[i-1];
    end
    los_cell u_cell (
      .clk_i     (clk_i),
      .ins_en_i  (ins_en),
      .valid_i   (count_q > POS),
      .new_i     (new_ent),
      .prev_i    (prev_ent),
      .prev_gt_i (prev_gt),
      .ent_o     (cell_ent[i]),
      .gt_o      (cell_gt[i])
    );
  end

  // Fill count.
  always_comb begin
    count_d = count_q;
    if (v2_q && (op2_q == los_pkg::OP_CLEAR)) begin
      count_d = '0;
    end else if (ins_en && (count_q < CNT_MAX)) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Readout sequencer walks the cells in rank order into the output register.
  assign last_pos = count_q - CNT_W'(1);
  assign rd_load  = (st_q == ST_READ) && (!out_valid_q || !out_stall_i);
  assign rd_last  = (count_q == '0) || (rd_idx_q == last_pos[IDX_W-1:0]);

  always_comb begin
    st_d        = st_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_tag_d   = out_tag_q;
    out_area_d  = out_area_q;
    out_rank_d  = out_rank_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    if (v2_q && (op2_q == los_pkg::OP_READ)) begin
      st_d     = ST_READ;
      rd_idx_d = '0;
    end else if (rd_load) begin
      out_valid_d = 1'b1;
      out_rank_d  = los_pkg::RANK_W'(rd_idx_q);
      out_last_d  = rd_last;
      if (count_q == '0) begin
        out_tag_d   = '0;
        out_area_d  = '0;
        out_empty_d = 1'b1;
      end else begin
        out_tag_d   = cell_ent[rd_idx_q].tag;
        out_area_d  = cell_ent[rd_idx_q].area;
        out_empty_d = 1'b0;
      end
      if (rd_last) begin
        st_d = ST_IDLE;
      end else begin
        rd_idx_d = rd_idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tag_q   <= out_tag_d;
    out_area_q  <= out_area_d;
    out_rank_q  <= out_rank_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o = out_valid_q;
  assign kept_tag_o  = out_tag_q;
  assign kept_area_o = out_area_q;
  assign rank_o      = out_rank_q;
  assign is_last_o   = out_last_q;
  assign is_empty_o  = out_empty_q;

endmodule

[rtl/los_area.sv]
module los_area (
  input  logic                                clk_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  origin_z_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_a_z_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_x_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_y_i,
  input  logic signed [los_pkg::COORD_W-1:0]  side_b_z_i,
  output logic        [los_pkg::AREA_W-1:0]   area_o
);

  // Magnitude of the difference of two coordinates, which always fits in 24 bits.
  function automatic logic [los_pkg::COORD_W-1:0] abs_diff(
    input logic [los_pkg::COORD_W-1:0] a,
    input logic [los_pkg::COORD_W-1:0] b
  );
    logic [los_pkg::COORD_W:0] d;
    logic [los_pkg::COORD_W:0] m;
    d = {a[los_pkg::COORD_W-1], a} - {b[los_pkg::COORD_W-1], b};
    m = d[los_pkg::COORD_W] ? (~d + {{los_pkg::COORD_W{1'b0}}, 1'b1}) : d;
    return m[los_pkg::COORD_W-1:0];
  endfunction

  logic [los_pkg::SUM_W-1:0]  sum_a_d, sum_a_q;
  logic [los_pkg::SUM_W-1:0]  sum_b_d, sum_b_q;
  logic [los_pkg::AREA_W-1:0] area_d, area_q;

  // First stage: Manhattan lengths of both edges.
  always_comb begin
    sum_a_d = los_pkg::SUM_W'(abs_diff(side_a_x_i, origin_x_i))
            + los_pkg::SUM_W'(abs_diff(side_a_y_i, origin_y_i))
            + los_pkg::SUM_W'(abs_diff(side_a_z_i, origin_z_i));
    sum_b_d = los_pkg::SUM_W'(abs_diff(side_b_x_i, origin_x_i))
            + los_pkg::SUM_W'(abs_diff(side_b_y_i, origin_y_i))
            + los_pkg::SUM_W'(abs_diff(side_b_z_i, origin_z_i));
  end

  // Second stage: one 26 by 26 product.
  assign area_d = los_pkg::AREA_W'(sum_a_q) * los_pkg::AREA_W'(sum_b_q);

  always_ff @(posedge clk_i) begin
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
    area_q  <= area_d;
  end

  assign area_o = area_q;

endmodule

[rtl/los_cell.sv]
module los_cell (
  input  logic            clk_i,
  input  logic            ins_en_i,
  input  logic            valid_i,
  input  los_pkg::entry_t new_i,
  input  los_pkg::entry_t prev_i,
  input  logic            prev_gt_i,
  output los_pkg::entry_t ent_o,
  output logic            gt_o
);

  los_pkg::entry_t ent_d, ent_q;

  // The new quad goes ahead of this entry when it is strictly larger or the cell is empty.
  assign gt_o = !valid_i || (new_i.area > ent_q.area);

  // Take the neighbor's entry when the insertion point lies above, else the new one.
  always_comb begin
    ent_d = ent_q;
    if (ins_en_i && gt_o) begin
      ent_d = prev_gt_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

[rtl/los_checker.sv]
`include "largest_occluder_selection_unit_defines.svh"

module los_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [los_pkg::TAG_W-1:0]         kept_tag_o,
  input logic [los_pkg::AREA_W-1:0]        kept_area_o,
  input logic [los_pkg::RANK_W-1:0]        rank_o,
  input logic                              is_last_o,
  input logic                              is_empty_o
);

  // A stalled result beat stays offered.
  `LOS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "out beat dropped under stall")

  // A stalled result beat keeps its payload.
  `LOS_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(kept_tag_o) && $stable(kept_area_o) && $stable(rank_o) && $stable(is_last_o), "out payload changed under stall")

  // The empty marker is a single zero beat at rank zero.
  `LOS_ASSERT(a_empty_beat, clk_i, rst_ni, out_valid_o && is_empty_o |-> is_last_o && (rank_o == '0) && (kept_area_o == '0) && (kept_tag_o == '0), "malformed empty beat")

  // Within a readout the next beat follows at once with the next rank.
  `LOS_ASSERT(a_rank_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !is_last_o |=> out_valid_o && (rank_o == los_pkg::RANK_W'($past(rank_o) + 1'b1)), "rank did not advance")

endmodule

bind largest_occluder_selection_unit los_checker u_los_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint unsigned TIMEOUT_NS = 20_000_000;
  localparam logic [los_pkg::AREA_W-1:0] AREA_TOP = 52'd2533274790395904;
  // The one code that the block must ignore.
  localparam logic [los_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Corners in order: origin x,y,z, side a x,y,z, side b x,y,z.
  typedef struct packed {
    logic [los_pkg::OP_W-1:0]              op;
    logic [los_pkg::TAG_W-1:0]             tag;
    logic [8:0][los_pkg::COORD_W-1:0]      pt;
  } quad_beat_t;

  typedef struct packed {
    logic [los_pkg::TAG_W-1:0]  tag;
    logic [los_pkg::AREA_W-1:0] area;
    logic [los_pkg::RANK_W-1:0] rank;
    logic                       last;
    logic                       empty;
  } kept_result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic        [los_pkg::AREA_W-1:0]  cfg_wdata_i = '0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic        [los_pkg::OP_W-1:0]    operation_i = los_pkg::OP_CLEAR;
  logic        [los_pkg::TAG_W-1:0]   quad_tag_i = '0;
  logic signed [los_pkg::COORD_W-1:0] origin_x_i = '0;
  logic signed [los_pkg::COORD_W-1:0] origin_y_i = '0;
  logic signed [los_pkg::COORD_W-1:0] origin_z_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_a_x_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_a_y_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_a_z_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_b_x_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_b_y_i = '0;
  logic signed [los_pkg::COORD_W-1:0] side_b_z_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic        [los_pkg::TAG_W-1:0]   kept_tag_o;
  logic        [los_pkg::AREA_W-1:0]  kept_area_o;
  logic        [los_pkg::RANK_W-1:0]  rank_o;
  logic                               is_last_o;
  logic                               is_empty_o;

  largest_occluder_selection_unit #(
    .MAX_QUADS(LIST_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .quad_tag_i (quad_tag_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .origin_z_i (origin_z_i),
    .side_a_x_i (side_a_x_i),
    .side_a_y_i (side_a_y_i),
    .side_a_z_i (side_a_z_i),
    .side_b_x_i (side_b_x_i),
    .side_b_y_i (side_b_y_i),
    .side_b_z_i (side_b_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kept_tag_o (kept_tag_o),
    .kept_area_o(kept_area_o),
    .rank_o     (rank_o),
    .is_last_o  (is_last_o),
    .is_empty_o (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // Shared state of stimulus, predictor and checker.
  quad_beat_t                 pending_beats[$];
  kept_result_t               readout_q[$];
  logic [los_pkg::AREA_W-1:0] kept_areas[LIST_DEPTH];
  logic [los_pkg::TAG_W-1:0]  kept_tags[LIST_DEPTH];
  int unsigned                kept_len = 0;
  logic [los_pkg::AREA_W-1:0] area_floor = los_pkg::MIN_AREA_RST;
  int unsigned                fail_count = 0;
  int unsigned                send_gap = 0;
  int unsigned                recv_gap = 0;
  bit                         send_calm = 1'b0;
  bit                         recv_calm = 1'b0;
  logic                       hold_off = 1'b0;
  quad_beat_t                 drive_beat;
  quad_beat_t                 seen_beat;
  event                       hold_off_ev;

  // Idle length between beats: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Sum of absolute coordinate differences from the origin to one side corner.
  function automatic logic [los_pkg::AREA_W-1:0] edge_sum(
    logic [8:0][los_pkg::COORD_W-1:0] pt, int base);
    longint                     d;
    logic [los_pkg::AREA_W-1:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      d = longint'($signed(pt[base + k])) - longint'($signed(pt[k]));
      s = s + los_pkg::AREA_W'((d < 0) ? -d : d);
    end
    return s;
  endfunction

  // Track the list as the block should hold it; queue the beats a readout gives.
  task automatic track_list(quad_beat_t b);
    logic [los_pkg::AREA_W-1:0] area;
    int unsigned                slot;
    kept_result_t               res;
    unique case (b.op)
      los_pkg::OP_CLEAR: kept_len = 0;
      los_pkg::OP_OFFER: begin
        area = edge_sum(b.pt, 3) * edge_sum(b.pt, 6);
        if (area >= area_floor) begin
          if (kept_len >= LIST_DEPTH) begin
            if (area <= kept_areas[LIST_DEPTH-1]) return;
            slot = LIST_DEPTH - 1;
          end else begin
            slot = kept_len;
            kept_len++;
          end
          // Shift smaller entries down; equal areas stay ahead of the new one.
          while (slot > 0 && area > kept_areas[slot-1]) begin
            kept_areas[slot] = kept_areas[slot-1];
            kept_tags[slot] = kept_tags[slot-1];
            slot--;
          end
          kept_areas[slot] = area;
          kept_tags[slot] = b.tag;
        end
      end
      los_pkg::OP_READ: begin
        if (kept_len == 0) begin
          res = '{tag: '0, area: '0, rank: '0, last: 1'b1, empty: 1'b1};
          readout_q.push_back(res);
        end else begin
          for (int unsigned k = 0; k < kept_len; k++) begin
            res = '{tag: kept_tags[k], area: kept_areas[k], rank: k[los_pkg::RANK_W-1:0],
                    last: (k + 1 == kept_len), empty: 1'b0};
            readout_q.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  // Compare one result beat with the oldest expected one.
  task automatic check_result();
    kept_result_t want;
    if (readout_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result beat with nothing expected, tag 0x%0h rank %0d",
                 $time, kept_tag_o, rank_o);
      return;
    end
    want = readout_q.pop_front();
    if (kept_tag_o !== want.tag)
      flag_mismatch("kept_tag", 64'(want.tag), 64'(kept_tag_o));
    if (kept_area_o !== want.area)
      flag_mismatch("kept_area", 64'(want.area), 64'(kept_area_o));
    if (rank_o !== want.rank)
      flag_mismatch("rank", 64'(want.rank), 64'(rank_o));
    if (is_last_o !== want.last)
      flag_mismatch("is_last", 64'(want.last), 64'(is_last_o));
    if (is_empty_o !== want.empty)
      flag_mismatch("is_empty", 64'(want.empty), 64'(is_empty_o));
  endtask

  // Monitor: follow register writes, predict on accepted beats, check results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) area_floor = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        seen_beat.op = operation_i;
        seen_beat.tag = quad_tag_i;
        seen_beat.pt = {side_b_z_i, side_b_y_i, side_b_x_i, side_a_z_i, side_a_y_i,
                        side_a_x_i, origin_z_i, origin_y_i, origin_x_i};
        track_list(seen_beat);
      end
      if (out_valid_o && !out_stall_i) check_result();
    end
  end

  // Driver: present the next pending beat once the current one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        drive_beat = pending_beats.pop_front();
        operation_i <= drive_beat.op;
        quad_tag_i <= drive_beat.tag;
        origin_x_i <= drive_beat.pt[0];
        origin_y_i <= drive_beat.pt[1];
        origin_z_i <= drive_beat.pt[2];
        side_a_x_i <= drive_beat.pt[3];
        side_a_y_i <= drive_beat.pt[4];
        side_a_z_i <= drive_beat.pt[5];
        side_b_x_i <= drive_beat.pt[6];
        side_b_y_i <= drive_beat.pt[7];
        side_b_z_i <= drive_beat.pt[8];
        in_valid_i <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a solid stall while a hold-off is running.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        recv_gap = pick_gap(recv_calm);
        out_stall_i <= (recv_gap > 0);
        if (recv_gap > 0) recv_gap--;
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up to its input.
  always begin
    @(hold_off_ev);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Beat with every field random and the given operation.
  function automatic quad_beat_t noise_beat(logic [los_pkg::OP_W-1:0] op);
    quad_beat_t b;
    b.op = op;
    b.tag = los_pkg::TAG_W'($urandom);
    for (int k = 0; k < 9; k++) b.pt[k] = los_pkg::COORD_W'($urandom);
    return b;
  endfunction

  // Offer built from an origin and the edge vectors to both side corners.
  function automatic quad_beat_t quad_offer(int unsigned tag, int ox, int oy, int oz,
                                            int ax, int ay, int az, int bx, int by, int bz);
    quad_beat_t b;
    int         c[9];
    c = '{ox, oy, oz, ox + ax, oy + ay, oz + az, ox + bx, oy + by, oz + bz};
    b.op = los_pkg::OP_OFFER;
    b.tag = tag[los_pkg::TAG_W-1:0];
    for (int k = 0; k < 9; k++) b.pt[k] = c[k][los_pkg::COORD_W-1:0];
    return b;
  endfunction

  // Edge component; a small set of values makes equal areas common.
  function automatic int pick_delta(bit ties);
    if (ties || $urandom_range(0, 3) == 0) begin
      unique case ($urandom_range(0, 4))
        0: return -512;
        1: return -256;
        2: return 0;
        3: return 256;
        default: return 512;
      endcase
    end
    return int'($urandom_range(0, 2048)) - 1024;
  endfunction

  function automatic quad_beat_t small_offer(bit ties);
    int o[3];
    for (int k = 0; k < 3; k++) o[k] = int'($urandom_range(0, 8388608)) - 4194304;
    return quad_offer($urandom, o[0], o[1], o[2],
                      pick_delta(ties), pick_delta(ties), pick_delta(ties),
                      pick_delta(ties), pick_delta(ties), pick_delta(ties));
  endfunction

  // A clear (usually), a run of offers with the odd readout, then a readout.
  task automatic push_sequence(output int unsigned n);
    bit          ties;
    int unsigned len;
    ties = ($urandom_range(0, 2) == 0);
    len = $urandom_range(0, 26);
    n = len + 1;
    if ($urandom_range(0, 9) < 7) begin
      pending_beats.push_back(noise_beat(los_pkg::OP_CLEAR));
      n++;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) pending_beats.push_back(noise_beat(los_pkg::OP_READ));
      else if ($urandom_range(0, 6) == 0)
        pending_beats.push_back(noise_beat(los_pkg::OP_OFFER));
      else pending_beats.push_back(small_offer(ties));
    end
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned               count;
    int unsigned               n;
    logic [los_pkg::OP_W-1:0]  op;
    count = 0;
    while (count < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        op = los_pkg::OP_W'($urandom_range(0, 3));
        pending_beats.push_back(noise_beat(op));
        if (op != OP_UNUSED) count++;
      end else begin
        push_sequence(n);
        count += n;
      end
    end
  endtask

  // Wait until every beat is sent and every result is in, then let offers land.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || readout_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_floor(logic [los_pkg::AREA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [los_pkg::AREA_W-1:0] random_floor(
    logic [los_pkg::AREA_W-1:0] top);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return los_pkg::AREA_W'(r % (64'(top) + 64'd1));
  endfunction

  // Stimulus plan: directed checks at the reset threshold, then random phases.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty readout, ignored code, and the threshold boundary.
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    pending_beats.push_back(noise_beat(OP_UNUSED));
    pending_beats.push_back(quad_offer(1, 700, -300, 20, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(quad_offer(2, 1000, -2000, 300, 512, 0, 0, 0, 512, 0));
    pending_beats.push_back(quad_offer(3, -5, 9, 77, 0, 512, 0, 0, 0, 511));
    // Equal area with negative edges goes behind the earlier entry.
    pending_beats.push_back(quad_offer(4, 40, 40, 40, -256, -256, 0, 0, 0, -512));
    // Largest possible area, from both corners of the coordinate range.
    pending_beats.push_back(quad_offer(5, -8388608, -8388608, -8388608,
                                       16777215, 16777215, 16777215,
                                       16777215, 16777215, 16777215));
    pending_beats.push_back(quad_offer(6, 8388607, 8388607, 8388607,
                                       -16777215, -16777215, -16777215,
                                       -16777215, -16777215, -16777215));
    pending_beats.push_back(quad_offer(20'hFFFFF, 0, 0, 0, 1024, -1024, 0, 0, 0, 768));
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    // Clear empties the list; a single entry is both first and last.
    pending_beats.push_back(noise_beat(los_pkg::OP_CLEAR));
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    pending_beats.push_back(quad_offer(0, 100, -100, 50, 300, -200, 0, 0, 600, -100));
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    pending_beats.push_back(noise_beat(OP_UNUSED));
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    pending_beats.push_back(noise_beat(los_pkg::OP_CLEAR));
    pending_beats.push_back(noise_beat(OP_UNUSED));
    pending_beats.push_back(noise_beat(los_pkg::OP_READ));
    wait_drained();

    // Zero threshold keeps degenerate quads.
    write_floor('0);
    run_phase(100);
    wait_drained();

    // Threshold among the small quad areas, so some are dropped.
    write_floor(random_floor(52'd4194304));
    run_phase(120);
    wait_drained();

    // Top threshold: nothing can be kept.
    write_floor(AREA_TOP);
    run_phase(30);
    wait_drained();

    write_floor(random_floor(AREA_TOP));
    run_phase(80);
    wait_drained();

    // Back to the reset value with a long receiver hold-off at the start.
    write_floor(los_pkg::MIN_AREA_RST);
    -> hold_off_ev;
    run_phase(150);
    wait_drained();

    if (fail_count == 0) begin
      $display("largest_occluder_selection_unit verification clean");
    end else begin
      $display("largest_occluder_selection_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("largest_occluder_selection_unit verification failed");
    $finish;
  end

endmodule
